/* src/sbus_rx_pkg.sv */
package sbus_rx_pkg;

    // Frame geometry
    localparam int FRAME_BYTES = 25;
    localparam int POS_W       = 5;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    // Start and end markers
    localparam logic [7:0] BEGIN_BYTE   = 8'h0F;
    localparam logic [7:0] MARK_SLOT    = 8'h00;
    localparam logic [7:0] MARK_PAGE0   = 8'h04;
    localparam logic [7:0] MARK_SHORT   = 8'h08;
    localparam logic [7:0] MARK_PAGE1   = 8'h14;
    localparam logic [7:0] MARK_PAGE2   = 8'h24;
    localparam logic [7:0] MARK_PAGE3   = 8'h34;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_INTERVAL       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_SYNC_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_GAP            = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SBUS2_MODE          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BEGIN          = 3'd4;

    // Configuration reset values
    localparam logic [15:0] SYNC_INTERVAL_RST       = 16'd3000;
    localparam logic [15:0] SHORT_SYNC_INTERVAL_RST = 16'd1650;
    localparam logic [15:0] BYTE_GAP_RST            = 16'd360;
    localparam logic [7:0]  HIGH_BEGIN_RST          = 8'd32;

    // Frame time mark codes
    typedef enum logic [1:0] {
        TMARK_NONE  = 2'd0,
        TMARK_SET   = 2'd1,
        TMARK_CLEAR = 2'd2
    } tmark_t;

    // One result item
    typedef struct packed {
        logic [7:0]       data_byte;
        logic [POS_W-1:0] byte_index;
        logic             byte_stored;
        logic             frame_end;
        logic             frame_valid;
        logic             frame_delivered;
        logic             high_frame;
        logic             twenty_six_channel;
        logic [3:0]       telemetry_page;
        logic             slot_reset;
        logic             short_interval;
        tmark_t           time_mark;
    } result_t;

    // End markers that carry telemetry meaning
    function automatic logic is_telemetry_marker(input logic [7:0] b);
        return (b == MARK_SLOT) || (b == MARK_PAGE0) || (b == MARK_PAGE1) ||
               (b == MARK_PAGE2) || (b == MARK_PAGE3);
    endfunction

endpackage

/* src/sbus_frame_receiver_top.sv */
// Results are registered: a result enters the output register, or the skid register when the output is held.
// Throughput: one byte per cycle; the frame state updates in the cycle of
// the input transfer, and a two-entry output stage (result plus skid
// register) takes one more byte while a result waits on the output side;
// the input stalls only once both entries are full.
// Reset: rst_n is asynchronous, active low; it returns the decoder to the
// sync state, clears flags and page, and loads the default register values.
module sbus_frame_receiver_top (
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_write,
    input  logic [sbus_rx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                cfg_data,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 rx_byte,
    input  logic [15:0]                gap_us,
    input  logic                       frame_released,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 data_byte,
    output logic [sbus_rx_pkg::POS_W-1:0] byte_index,
    output logic                       byte_stored,
    output logic                       frame_end,
    output logic                       frame_valid,
    output logic                       frame_delivered,
    output logic                       high_frame,
    output logic                       twenty_six_channel,
    output logic [3:0]                 telemetry_page,
    output logic                       slot_reset,
    output logic                       short_interval,
    output logic [1:0]                 time_mark
);
    import sbus_rx_pkg::*;

    typedef enum logic [1:0] {
        ST_SYNC,
        ST_PAYLOAD,
        ST_PAYLOAD_HIGH,
        ST_WAIT
    } state_t;

    // Configuration registers
    logic [15:0] sync_interval_reg;
    logic [15:0] short_sync_interval_reg;
    logic [15:0] byte_gap_reg;
    logic        sbus2_mode_reg;
    logic [7:0]  high_begin_reg;

    // Decoder state
    state_t           state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             pending_reg, pending_next;
    logic             seen26_reg, seen26_next;
    logic [3:0]       page_reg, page_next;
    logic             short_reg, short_next;

    // Output stage
    logic    out_valid_reg, skid_valid_reg;
    result_t out_res_reg, skid_res_reg;
    result_t res;

    logic        in_xfer;
    logic        out_free;
    state_t      st_pre;
    logic        pending_pre;
    logic [15:0] sync_gap;
    logic        marker_ok;

    assign in_stall = skid_valid_reg;
    assign in_xfer  = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;

    // Decode one byte
    always_comb
    begin
        sync_gap    = short_reg ? short_sync_interval_reg : sync_interval_reg;
        pending_pre = frame_released ? 1'b0 : pending_reg;
        marker_ok   = is_telemetry_marker(rx_byte);

        // Resync on a quiet gap, a pause inside a payload, or in SBUS2 mode a byte gap in any state
        st_pre = state_reg;
        if ((state_reg == ST_WAIT && gap_us >= sync_gap) ||
            (sbus2_mode_reg && gap_us >= byte_gap_reg))
        begin
            st_pre = ST_SYNC;
        end
        else if ((state_reg == ST_PAYLOAD || state_reg == ST_PAYLOAD_HIGH) &&
                 gap_us >= byte_gap_reg)
        begin
            st_pre = ST_SYNC;
        end

        state_next   = st_pre;
        pos_next     = pos_reg;
        pending_next = pending_pre;
        seen26_next  = seen26_reg;
        page_next    = page_reg;
        short_next   = short_reg;

        res                 = '0;
        res.data_byte       = rx_byte;
        res.time_mark       = TMARK_NONE;

        unique case (st_pre)
            ST_SYNC:
            begin
                if (rx_byte == BEGIN_BYTE || rx_byte == high_begin_reg)
                begin
                    res.byte_stored = 1'b1;
                    pos_next        = POS_W'(1);
                    state_next      = (rx_byte == BEGIN_BYTE) ? ST_PAYLOAD
                                                              : ST_PAYLOAD_HIGH;
                end
            end
            ST_PAYLOAD, ST_PAYLOAD_HIGH:
            begin
                res.byte_index  = pos_reg;
                res.byte_stored = 1'b1;
                if (pos_reg >= LAST_POS)
                begin
                    res.frame_end = 1'b1;
                    pos_next      = '0;
                    if (st_pre == ST_PAYLOAD)
                    begin
                        if (marker_ok || rx_byte == MARK_SHORT)
                        begin
                            res.frame_valid = 1'b1;
                            if (rx_byte[2])
                            begin
                                page_next     = rx_byte[7:4];
                                res.time_mark = TMARK_SET;
                            end
                            else if (rx_byte == MARK_SHORT)
                            begin
                                short_next = 1'b1;
                            end
                            else
                            begin
                                page_next      = '0;
                                res.slot_reset = 1'b1;
                                res.time_mark  = TMARK_CLEAR;
                            end
                        end
                        state_next = ST_WAIT;
                    end
                    else
                    begin
                        res.high_frame = 1'b1;
                        if (marker_ok)
                        begin
                            res.frame_valid = 1'b1;
                            res.time_mark   = TMARK_CLEAR;
                            state_next      = ST_SYNC;
                        end
                        else
                        begin
                            state_next = ST_WAIT;
                        end
                    end
                    // Hand on a valid frame only when none is pending
                    if (res.frame_valid && !pending_pre)
                    begin
                        res.frame_delivered = 1'b1;
                        pending_next        = 1'b1;
                        if (res.high_frame)
                        begin
                            seen26_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            ST_WAIT:
            begin
            end
            default:
            begin
            end
        endcase

        res.twenty_six_channel = seen26_next;
        res.telemetry_page     = page_next;
        res.short_interval     = short_next;
    end

    // Hold state, configuration and the output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_interval_reg       <= SYNC_INTERVAL_RST;
            short_sync_interval_reg <= SHORT_SYNC_INTERVAL_RST;
            byte_gap_reg            <= BYTE_GAP_RST;
            sbus2_mode_reg          <= 1'b0;
            high_begin_reg          <= HIGH_BEGIN_RST;
            state_reg               <= ST_SYNC;
            pos_reg                 <= '0;
            pending_reg             <= 1'b0;
            seen26_reg              <= 1'b0;
            page_reg                <= '0;
            short_reg               <= 1'b0;
            out_valid_reg           <= 1'b0;
            skid_valid_reg          <= 1'b0;
            out_res_reg             <= '0;
            skid_res_reg            <= '0;
        end
        else
        begin
            // Register writes
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_SYNC_INTERVAL:       sync_interval_reg       <= cfg_data;
                    CFG_SHORT_SYNC_INTERVAL: short_sync_interval_reg <= cfg_data;
                    CFG_BYTE_GAP:            byte_gap_reg            <= cfg_data;
                    CFG_SBUS2_MODE:          sbus2_mode_reg          <= cfg_data[0];
                    CFG_HIGH_BEGIN:          high_begin_reg          <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end

            // Advance the decoder on each input transfer
            if (in_xfer)
            begin
                state_reg   <= state_next;
                pos_reg     <= pos_next;
                pending_reg <= pending_next;
                seen26_reg  <= seen26_next;
                page_reg    <= page_next;
                short_reg   <= short_next;
            end

            // Result register with skid entry behind it
            if (out_free)
            begin
                if (skid_valid_reg)
                begin
                    out_res_reg    <= skid_res_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else if (in_xfer)
                begin
                    out_res_reg   <= res;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (in_xfer)
            begin
                skid_res_reg   <= res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Drive result ports
    assign out_valid          = out_valid_reg;
    assign data_byte          = out_res_reg.data_byte;
    assign byte_index         = out_res_reg.byte_index;
    assign byte_stored        = out_res_reg.byte_stored;
    assign frame_end          = out_res_reg.frame_end;
    assign frame_valid        = out_res_reg.frame_valid;
    assign frame_delivered    = out_res_reg.frame_delivered;
    assign high_frame         = out_res_reg.high_frame;
    assign twenty_six_channel = out_res_reg.twenty_six_channel;
    assign telemetry_page     = out_res_reg.telemetry_page;
    assign slot_reset         = out_res_reg.slot_reset;
    assign short_interval     = out_res_reg.short_interval;
    assign time_mark          = out_res_reg.time_mark;

endmodule

/* tb/sbus_frame_receiver_top_tb.sv */
`timescale 1ns / 100ps

module sbus_frame_receiver_top_tb;

    import sbus_rx_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_DIR_ROWS = 25;
    localparam int NUM_PHASES = 6;
    localparam int MAX_PRINTED = 50;

    typedef enum logic [1:0] {
        DEC_SYNC,
        DEC_NORMAL,
        DEC_HIGH,
        DEC_WAIT
    } decoder_state_t;

    // One row of the directed table; reps repeats the byte with the same gap
    typedef struct packed {
        logic [7:0]  rx;
        logic [15:0] gap;
        logic        rel;
        logic [7:0]  reps;
        logic        typed;
        result_t     want;
    } dir_row_t;

    // Register settings of one phase of the random part
    typedef struct packed {
        logic [15:0] sync_gap;
        logic [15:0] short_gap;
        logic [15:0] byte_gap;
        logic        sbus2;
        logic [7:0]  high_start;
        logic [15:0] goal;
    } phase_t;

    localparam result_t NO_TYPED = '0;
    localparam logic [7:0] FILL = 8'hA5;

    localparam dir_row_t DIR_TAB [NUM_DIR_ROWS] = '{
        // wrong bytes in sync, gap extremes
        '{8'h55, 16'd0, 1'b0, 8'd1, 1'b1, result_t'({8'h55, 19'd0})},
        '{8'hFF, 16'hFFFF, 1'b1, 8'd1, 1'b1, result_t'({8'hFF, 19'd0})},
        // high start, then a pause of one byte gap resyncs onto a normal start
        '{8'h20, 16'd0, 1'b0, 8'd1, 1'b1, result_t'({8'h20, 5'd0, 1'b1, 13'd0})},
        '{8'hFF, 16'd359, 1'b0, 8'd1, 1'b0, NO_TYPED},
        '{BEGIN_BYTE, 16'd360, 1'b0, 8'd1, 1'b1, result_t'({BEGIN_BYTE, 5'd0, 1'b1, 13'd0})},
        '{8'h00, 16'd0, 1'b0, 8'd1, 1'b0, NO_TYPED},
        '{FILL, 16'd100, 1'b0, 8'd21, 1'b0, NO_TYPED},
        '{8'hFF, 16'd359, 1'b0, 8'd1, 1'b0, NO_TYPED},
        '{MARK_SHORT, 16'd0, 1'b0, 8'd1, 1'b0, NO_TYPED},
        // short sync gap: one microsecond short, then exact
        '{BEGIN_BYTE, 16'd1649, 1'b0, 8'd1, 1'b0, NO_TYPED},
        '{BEGIN_BYTE, 16'd1650, 1'b0, 8'd1, 1'b0, NO_TYPED},
        '{FILL, 16'd100, 1'b0, 8'd23, 1'b0, NO_TYPED},
        '{MARK_PAGE0, 16'd0, 1'b0, 8'd1, 1'b0, NO_TYPED},
        '{BEGIN_BYTE, 16'd1650, 1'b1, 8'd1, 1'b0, NO_TYPED},
        '{FILL, 16'd100, 1'b0, 8'd23, 1'b0, NO_TYPED},
        '{MARK_PAGE3, 16'd0, 1'b0, 8'd1, 1'b0, NO_TYPED},
        // valid high frame, then an invalid one
        '{8'h20, 16'hFFFF, 1'b1, 8'd1, 1'b0, NO_TYPED},
        '{FILL, 16'd100, 1'b0, 8'd23, 1'b0, NO_TYPED},
        '{MARK_SLOT, 16'd0, 1'b0, 8'd1, 1'b0, NO_TYPED},
        '{8'h20, 16'd0, 1'b0, 8'd1, 1'b0, NO_TYPED},
        '{FILL, 16'd100, 1'b0, 8'd23, 1'b0, NO_TYPED},
        '{MARK_SHORT, 16'd0, 1'b0, 8'd1, 1'b0, NO_TYPED},
        // normal frame ending in the slot marker
        '{BEGIN_BYTE, 16'hFFFF, 1'b1, 8'd1, 1'b0, NO_TYPED},
        '{FILL, 16'd100, 1'b0, 8'd23, 1'b0, NO_TYPED},
        '{MARK_SLOT, 16'd0, 1'b0, 8'd1, 1'b0, NO_TYPED}
    };

    localparam phase_t PHASES [NUM_PHASES] = '{
        '{SYNC_INTERVAL_RST, SHORT_SYNC_INTERVAL_RST, BYTE_GAP_RST, 1'b0, HIGH_BEGIN_RST,
          16'd260},
        '{16'd0, 16'd0, 16'd0, 1'b0, BEGIN_BYTE, 16'd40},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 16'd260},
        '{16'd500, 16'd200, 16'd1, 1'b1, 8'h00, 16'd260},
        '{16'd0, 16'd0, 16'd0, 1'b0, 8'h00, 16'd260},
        '{16'd3000, 16'd1650, 16'd360, 1'b0, BEGIN_BYTE, 16'd260}
    };

    localparam logic [7:0] END_MARKS [6] = '{
        MARK_SLOT, MARK_PAGE0, MARK_SHORT, MARK_PAGE1, MARK_PAGE2, MARK_PAGE3
    };

    // Idle percentages per mode: none, sender, receiver, both
    localparam int SEND_IDLE [4] = '{0, 69, 0, 19};
    localparam int RECV_IDLE [4] = '{0, 0, 69, 19};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = '0;
    logic [15:0] gap_us = '0;
    logic        frame_released = 1'b0;

    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [7:0]       data_byte;
    logic [POS_W-1:0] byte_index;
    logic             byte_stored;
    logic             frame_end;
    logic             frame_valid;
    logic             frame_delivered;
    logic             high_frame;
    logic             twenty_six_channel;
    logic [3:0]       telemetry_page;
    logic             slot_reset;
    logic             short_interval;
    logic [1:0]       time_mark;

    // Decoder state and register copies as the predictor sees them
    decoder_state_t   dec_state = DEC_SYNC;
    logic [POS_W-1:0] pos_cnt = '0;
    logic             pend_flag = 1'b0;
    logic             high_seen = 1'b0;
    logic [3:0]       page_cur = '0;
    logic             short_seen = 1'b0;
    logic [15:0]      sync_gap_cfg = SYNC_INTERVAL_RST;
    logic [15:0]      short_gap_cfg = SHORT_SYNC_INTERVAL_RST;
    logic [15:0]      byte_gap_cfg = BYTE_GAP_RST;
    logic             sbus2_cfg = 1'b0;
    logic [7:0]       high_start_cfg = HIGH_BEGIN_RST;

    result_t     byte_results_q [$];
    int unsigned mismatch_count = 0;
    int unsigned n_sent = 0;
    int unsigned n_results = 0;
    int unsigned cycle_count = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;

    sbus_frame_receiver_top DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .rx_byte            (rx_byte),
        .gap_us             (gap_us),
        .frame_released     (frame_released),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .data_byte          (data_byte),
        .byte_index         (byte_index),
        .byte_stored        (byte_stored),
        .frame_end          (frame_end),
        .frame_valid        (frame_valid),
        .frame_delivered    (frame_delivered),
        .high_frame         (high_frame),
        .twenty_six_channel (twenty_six_channel),
        .telemetry_page     (telemetry_page),
        .slot_reset         (slot_reset),
        .short_interval     (short_interval),
        .time_mark          (time_mark)
    );

    always #5 clk = ~clk;

    // Advance the decoder by one byte and return the result it produces
    function automatic result_t decode_byte(input logic [7:0] rx, input logic [15:0] gap,
                                            input logic rel);
        result_t     r;
        logic [15:0] need;
        logic        is_mark;
        r = '0;
        r.data_byte = rx;
        need = short_seen ? short_gap_cfg : sync_gap_cfg;
        is_mark = (rx == MARK_SLOT) || (rx == MARK_PAGE0) || (rx == MARK_PAGE1) ||
                  (rx == MARK_PAGE2) || (rx == MARK_PAGE3);
        if (rel)
            pend_flag = 1'b0;
        if ((dec_state == DEC_WAIT && gap >= need) || (sbus2_cfg && gap >= byte_gap_cfg))
            dec_state = DEC_SYNC;
        else if ((dec_state == DEC_NORMAL || dec_state == DEC_HIGH) && gap >= byte_gap_cfg)
            dec_state = DEC_SYNC;
        case (dec_state)
            DEC_SYNC:
            begin
                if (rx == BEGIN_BYTE || rx == high_start_cfg)
                begin
                    r.byte_stored = 1'b1;
                    pos_cnt = 5'd1;
                    dec_state = (rx == BEGIN_BYTE) ? DEC_NORMAL : DEC_HIGH;
                end
            end
            DEC_NORMAL, DEC_HIGH:
            begin
                r.byte_index = pos_cnt;
                r.byte_stored = 1'b1;
                if (pos_cnt >= LAST_POS)
                begin
                    r.frame_end = 1'b1;
                    pos_cnt = '0;
                    if (dec_state == DEC_NORMAL)
                    begin
                        if (is_mark || rx == MARK_SHORT)
                        begin
                            r.frame_valid = 1'b1;
                            if (rx[2])
                            begin
                                page_cur = rx[7:4];
                                r.time_mark = TMARK_SET;
                            end
                            else if (rx == MARK_SHORT)
                                short_seen = 1'b1;
                            else
                            begin
                                page_cur = '0;
                                r.slot_reset = 1'b1;
                                r.time_mark = TMARK_CLEAR;
                            end
                        end
                        dec_state = DEC_WAIT;
                    end
                    else
                    begin
                        r.high_frame = 1'b1;
                        if (is_mark)
                        begin
                            r.frame_valid = 1'b1;
                            r.time_mark = TMARK_CLEAR;
                            dec_state = DEC_SYNC;
                        end
                        else
                            dec_state = DEC_WAIT;
                    end
                    // hand on only if the consumer took the last frame
                    if (r.frame_valid && !pend_flag)
                    begin
                        r.frame_delivered = 1'b1;
                        pend_flag = 1'b1;
                        if (r.high_frame)
                            high_seen = 1'b1;
                    end
                end
                else
                    pos_cnt = pos_cnt + 5'd1;
            end
            default:
            begin
            end
        endcase
        r.twenty_six_channel = high_seen;
        r.telemetry_page = page_cur;
        r.short_interval = short_seen;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got_v,
                               input logic [7:0] want_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                      n_results, name, got_v, want_v));
    endtask

    // Drive one byte, hold it until transferred, then idle at random
    task automatic send_item(input logic [7:0] rx, input logic [15:0] gap, input logic rel,
                             input logic typed, input result_t typed_want);
        result_t want;
        in_valid <= 1'b1;
        rx_byte <= rx;
        gap_us <= gap;
        frame_released <= rel;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = decode_byte(rx, gap, rel);
        if (typed)
            want = typed_want;
        byte_results_q.push_back(want);
        n_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Hold off the sender until every predicted result has come out
    task automatic settle_outputs();
        in_valid <= 1'b0;
        while (byte_results_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_config(input phase_t p);
        logic [CFG_IDX_W-1:0] ids [5];
        logic [15:0]          vals [5];
        ids = '{CFG_SYNC_INTERVAL, CFG_SHORT_SYNC_INTERVAL, CFG_BYTE_GAP, CFG_SBUS2_MODE,
                CFG_HIGH_BEGIN};
        vals = '{p.sync_gap, p.short_gap, p.byte_gap, {15'd0, p.sbus2}, {8'd0, p.high_start}};
        for (int i = 0; i < 5; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= ids[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        sync_gap_cfg = p.sync_gap;
        short_gap_cfg = p.short_gap;
        byte_gap_cfg = p.byte_gap;
        sbus2_cfg = p.sbus2;
        high_start_cfg = p.high_start;
    endtask

    // Receiver stall
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (byte_results_q.size() == 0)
                report_mismatch($sformatf("result %0d with no byte pending", n_results));
            else
            begin
                want = byte_results_q.pop_front();
                check_field("data_byte", data_byte, want.data_byte);
                check_field("byte_index", {3'd0, byte_index}, {3'd0, want.byte_index});
                check_field("byte_stored", {7'd0, byte_stored}, {7'd0, want.byte_stored});
                check_field("frame_end", {7'd0, frame_end}, {7'd0, want.frame_end});
                check_field("frame_valid", {7'd0, frame_valid}, {7'd0, want.frame_valid});
                check_field("frame_delivered", {7'd0, frame_delivered},
                            {7'd0, want.frame_delivered});
                check_field("high_frame", {7'd0, high_frame}, {7'd0, want.high_frame});
                check_field("twenty_six_channel", {7'd0, twenty_six_channel},
                            {7'd0, want.twenty_six_channel});
                check_field("telemetry_page", {4'd0, telemetry_page},
                            {4'd0, want.telemetry_page});
                check_field("slot_reset", {7'd0, slot_reset}, {7'd0, want.slot_reset});
                check_field("short_interval", {7'd0, short_interval},
                            {7'd0, want.short_interval});
                check_field("time_mark", {6'd0, time_mark}, {6'd0, want.time_mark});
            end
            n_results++;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int          units;
        int          len;
        int unsigned goal;
        phase_t      cfg_now;
        logic [15:0] need;
        logic [15:0] lo;
        logic [15:0] gap;
        logic [7:0]  rx;

        units = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        idle_pct = SEND_IDLE[3];
        stall_pct = RECV_IDLE[3];
        for (int k = 0; k < NUM_DIR_ROWS; k++)
            for (int n = 0; n < int'(DIR_TAB[k].reps); n++)
                send_item(DIR_TAB[k].rx, DIR_TAB[k].gap, DIR_TAB[k].rel, DIR_TAB[k].typed,
                          DIR_TAB[k].want);

        // Random frames and noise, one register setting per phase
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            cfg_now = PHASES[ph];
            if (ph == 4)
            begin
                cfg_now.sync_gap = 16'($urandom_range(4000));
                cfg_now.short_gap = 16'($urandom_range(4000));
                cfg_now.byte_gap = 16'($urandom_range(1000, 20));
                cfg_now.sbus2 = 1'($urandom_range(1));
                cfg_now.high_start = 8'($urandom_range(255));
            end
            if (ph != 0)
            begin
                settle_outputs();
                write_config(cfg_now);
            end
            goal = n_sent + cfg_now.goal;
            while (n_sent < goal)
            begin
                idle_pct = SEND_IDLE[(units / 5) % 4];
                stall_pct = RECV_IDLE[(units / 5) % 4];
                if ($urandom_range(99) < 15)
                begin
                    // noise: random bytes and gaps, start bytes now and then
                    len = $urandom_range(8, 1);
                    for (int n = 0; n < len; n++)
                    begin
                        if ($urandom_range(3) == 0)
                            rx = $urandom_range(1) ? BEGIN_BYTE : high_start_cfg;
                        else
                            rx = 8'($urandom_range(255));
                        send_item(rx, 16'($urandom_range(65535)), $urandom_range(9) == 0,
                                  1'b0, NO_TYPED);
                    end
                end
                else
                begin
                    // frame, mostly well-formed: quiet gap, start byte, payload, end marker
                    need = short_seen ? short_gap_cfg : sync_gap_cfg;
                    lo = (need > byte_gap_cfg) ? need : byte_gap_cfg;
                    if ($urandom_range(9) == 0)
                        gap = 16'($urandom_range(65535));
                    else
                        gap = 16'($urandom_range(65535, lo));
                    rx = $urandom_range(1) ? BEGIN_BYTE : high_start_cfg;
                    send_item(rx, gap, $urandom_range(3) == 0, 1'b0, NO_TYPED);
                    for (int n = 1; n < FRAME_BYTES; n++)
                    begin
                        if (byte_gap_cfg != 0 && $urandom_range(19) != 0)
                            gap = 16'($urandom_range(byte_gap_cfg - 16'd1));
                        else
                            gap = 16'($urandom_range(65535));
                        if (n < FRAME_BYTES - 1)
                            rx = 8'($urandom_range(255));
                        else if ($urandom_range(3) != 0)
                            rx = END_MARKS[$urandom_range(5)];
                        else
                            rx = 8'($urandom_range(255));
                        send_item(rx, gap, $urandom_range(9) == 0, 1'b0, NO_TYPED);
                    end
                end
                if ($urandom_range(39) == 0)
                    settle_outputs();
                units++;
            end
        end

        // Drain and finish
        settle_outputs();
        repeat (5) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
